### hdl/sbt_pkg.sv
// Package with token types, kind codes, name tables and character class functions.
package sbt_pkg;

    localparam int WORD_BUF_LEN = 8;
    localparam int WORD_IDX_W   = $clog2(WORD_BUF_LEN);
    localparam int POS_W        = 16;
    localparam int KIND_W       = 6;
    localparam int NAT_W        = 3;
    localparam int LEN_W        = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int MAX_RESULTS  = 3;

    localparam logic [KIND_W-1:0] KIND_IDENT    = 6'd0;
    localparam logic [KIND_W-1:0] KIND_INT      = 6'd1;
    localparam logic [KIND_W-1:0] KIND_STRING   = 6'd2;
    localparam logic [KIND_W-1:0] KIND_NATIVE   = 6'd3;
    localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 6'd4;
    localparam logic [KIND_W-1:0] KIND_SYMBOL0  = 6'd22;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 6'd31;
    localparam logic [KIND_W-1:0] KIND_LT       = 6'd33;
    localparam logic [KIND_W-1:0] KIND_GT       = 6'd35;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 6'd37;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 6'd39;
    localparam logic [KIND_W-1:0] KIND_STAR     = 6'd41;
    localparam logic [KIND_W-1:0] KIND_SLASH    = 6'd42;
    localparam logic [KIND_W-1:0] KIND_PERCENT  = 6'd43;
    localparam logic [KIND_W-1:0] KIND_BANG     = 6'd44;
    localparam logic [KIND_W-1:0] KIND_END      = 6'd46;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 6'd47;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NL      = 8'h0A;

    localparam int NUM_NATIVE  = 7;
    localparam int NUM_KEYWORD = 18;
    localparam int NUM_SYMBOL  = 9;

    localparam logic [63:0] NATIVE_TEXT [NUM_NATIVE] = '{
        64'("write"), 64'("exit"), 64'("malloc"), 64'("mdealloc"),
        64'("mload"), 64'("mset"), 64'("sizeof")
    };
    localparam logic [3:0] NATIVE_LEN [NUM_NATIVE] = '{
        4'd5, 4'd4, 4'd6, 4'd8, 4'd5, 4'd4, 4'd6
    };
    localparam logic [63:0] KEYWORD_TEXT [NUM_KEYWORD] = '{
        64'("proc"), 64'("func"), 64'("return"), 64'("var"), 64'("if"),
        64'("else"), 64'("while"), 64'("for"), 64'("in"), 64'("use"),
        64'("as"), 64'("or"), 64'("and"), 64'("xor"), 64'("array"),
        64'("int"), 64'("str"), 64'("ptr")
    };
    localparam logic [3:0] KEYWORD_LEN [NUM_KEYWORD] = '{
        4'd4, 4'd4, 4'd6, 4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3,
        4'd2, 4'd2, 4'd3, 4'd3, 4'd5, 4'd3, 4'd3, 4'd3
    };
    localparam logic [7:0] SYMBOL_CHAR [NUM_SYMBOL] = '{
        8'h3B, 8'h3A, 8'h2C, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h7B, 8'h7D
    };

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_COMMENT, MODE_STRING, MODE_NUMBER, MODE_WORD, MODE_OPER
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NAT_W-1:0]  native;
        logic [LEN_W-1:0]  length;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  column;
        logic              final_tok;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_LT) || (c == CH_GT) || (c == CH_PLUS) ||
               (c == CH_MINUS) || (c == CH_BANG);
    endfunction

    function automatic logic [KIND_W-1:0] oper_single(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_EQ:    k = KIND_ASSIGN;
            CH_LT:    k = KIND_LT;
            CH_GT:    k = KIND_GT;
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            default:  k = KIND_BANG;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] oper_second(input logic [7:0] c);
        return ((c == CH_PLUS) || (c == CH_MINUS)) ? c : CH_EQ;
    endfunction

    // Name literals hold their first character in the highest used byte.
    function automatic logic name_match(input logic [WORD_BUF_LEN*8-1:0] buf_bits,
                                        input logic [LEN_W-1:0] len,
                                        input logic [63:0] text,
                                        input logic [3:0] tlen);
        logic ok;
        ok = (len == LEN_W'(tlen));
        for (int i = 0; i < 8; i++) begin
            if (i < int'(tlen)) begin
                if (buf_bits[i*8 +: 8] != text[(int'(tlen) - 1 - i)*8 +: 8]) ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [KIND_W+NAT_W-1:0] word_kind(
            input logic [WORD_BUF_LEN*8-1:0] buf_bits, input logic [LEN_W-1:0] len);
        logic [KIND_W-1:0] k;
        logic [NAT_W-1:0]  n;
        logic              hit;
        k = KIND_IDENT;
        n = '0;
        hit = 1'b0;
        for (int i = NUM_KEYWORD - 1; i >= 0; i--) begin
            if (name_match(buf_bits, len, KEYWORD_TEXT[i], KEYWORD_LEN[i])) begin
                k = KIND_KEYWORD0 + KIND_W'(i);
                hit = 1'b1;
            end
        end
        for (int i = NUM_NATIVE - 1; i >= 0; i--) begin
            if (name_match(buf_bits, len, NATIVE_TEXT[i], NATIVE_LEN[i])) begin
                k = KIND_NATIVE;
                n = NAT_W'(i);
            end
        end
        if (hit && (k != KIND_NATIVE)) n = '0;
        return {k, n};
    endfunction

endpackage

### hdl/source_byte_tokenizer_unit.sv
// Top level of the source byte tokenizer with stream ports.
// Output: tokens are written into the registered result queue and offered on m_axis from its head.
// Throughput: one byte per cycle while the four-entry result queue has room for three tokens;
// a byte that yields several tokens occupies the output for one transfer per token.
// Reset: aresetn low clears the scanner to line 1, column 1 and empties the result queue.
module source_byte_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [5:0] kind, [8:6] native, [24:9] length,
                                        // [40:25] line, [56:41] column, rest zero
    output logic        m_axis_tlast
);
    import sbt_pkg::*;

    token_t     toks [MAX_RESULTS];
    token_t     head;
    logic [1:0] tok_count;
    logic       room;
    logic       fire;

    assign s_axis_tready = room;
    assign fire = s_axis_tvalid && room;

    sbt_scanner u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .src_byte  (s_axis_tdata),
        .src_last  (s_axis_tlast),
        .tok_out   (toks),
        .tok_count (tok_count)
    );

    sbt_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_tok   (toks),
        .push_count (tok_count),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_tok    (head)
    );

    assign m_axis_tdata = {7'd0, head.column, head.line, head.length, head.native, head.kind};
    assign m_axis_tlast = head.final_tok;

endmodule

### hdl/sbt_scanner.sv
// Scanner state and token generation for one source byte.
module sbt_scanner (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic [7:0]           src_byte,
    input  logic                 src_last,
    output sbt_pkg::token_t      tok_out [sbt_pkg::MAX_RESULTS],
    output logic [1:0]           tok_count
);
    import sbt_pkg::*;

    scan_mode_t             mode_reg, mode_next;
    logic [7:0]             pend_reg, pend_next;
    logic [7:0]             wbuf_reg [WORD_BUF_LEN];
    logic [7:0]             wbuf_next [WORD_BUF_LEN];
    logic [LEN_W-1:0]       run_reg, run_next;
    logic [POS_W-1:0]       tline_reg, tline_next, tcol_reg, tcol_next;
    logic [POS_W-1:0]       line_reg, line_next, col_reg, col_next;
    logic [WORD_BUF_LEN*8-1:0] buf_cur, buf_new;
    logic [KIND_W+NAT_W-1:0]   wk_cur, wk_new;
    token_t                 cand [4];
    logic [3:0]             cand_v;
    logic                   consumed;
    logic [1:0]             cnt;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    always_comb begin
        for (int i = 0; i < WORD_BUF_LEN; i++) begin
            buf_cur[i*8 +: 8] = wbuf_reg[i];
        end
    end

    assign wk_cur = word_kind(buf_cur, run_reg);

    always_comb begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        wbuf_next  = wbuf_reg;
        run_next   = run_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        consumed   = 1'b0;
        cand_v     = '0;
        for (int i = 0; i < 4; i++) begin
            cand[i] = '{kind: KIND_ERROR, native: '0, length: LEN_W'(1),
                        line: line_reg, column: col_reg, final_tok: 1'b0};
        end
        cand[0].line   = tline_reg;
        cand[0].column = tcol_reg;

        case (mode_reg)
            MODE_WORD: begin
                if (is_word(src_byte)) begin
                    if (run_reg < LEN_W'(WORD_BUF_LEN)) begin
                        wbuf_next[run_reg[WORD_IDX_W-1:0]] = src_byte;
                    end
                    if (run_reg != LEN_MAX) run_next = run_reg + 1'b1;
                    consumed = 1'b1;
                end else begin
                    cand_v[0] = 1'b1;
                    cand[0].length = run_reg;
                    if (run_reg <= LEN_W'(WORD_BUF_LEN)) begin
                        cand[0].kind   = wk_cur[KIND_W+NAT_W-1:NAT_W];
                        cand[0].native = wk_cur[NAT_W-1:0];
                    end else begin
                        cand[0].kind = KIND_IDENT;
                    end
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(src_byte)) begin
                    if (run_reg != LEN_MAX) run_next = run_reg + 1'b1;
                    consumed = 1'b1;
                end else begin
                    cand_v[0] = 1'b1;
                    cand[0].kind = KIND_INT;
                    cand[0].length = run_reg;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_STRING: begin
                if (src_byte == CH_QUOTE) begin
                    cand_v[0] = 1'b1;
                    cand[0].kind = KIND_STRING;
                    cand[0].length = run_reg;
                    mode_next = MODE_IDLE;
                end else if (run_reg != LEN_MAX) begin
                    run_next = run_reg + 1'b1;
                end
                consumed = 1'b1;
            end
            MODE_COMMENT: begin
                if (src_byte == CH_NL) mode_next = MODE_IDLE;
                else consumed = 1'b1;
            end
            MODE_OPER: begin
                cand_v[0] = 1'b1;
                if (src_byte == oper_second(pend_reg)) begin
                    cand[0].kind = oper_single(pend_reg) + 1'b1;
                    cand[0].length = LEN_W'(2);
                    consumed = 1'b1;
                end else begin
                    cand[0].kind = oper_single(pend_reg);
                end
                pend_next = '0;
                mode_next = MODE_IDLE;
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (!consumed) begin
            tline_next = line_reg;
            tcol_next  = col_reg;
            cand_v[1]  = 1'b1;
            cand[1].kind = KIND_ERROR;
            for (int i = 0; i < NUM_SYMBOL; i++) begin
                if (src_byte == SYMBOL_CHAR[i]) cand[1].kind = KIND_SYMBOL0 + KIND_W'(i);
            end
            if (src_byte == CH_STAR) cand[1].kind = KIND_STAR;
            if (src_byte == CH_SLASH) cand[1].kind = KIND_SLASH;
            if (src_byte == CH_PERCENT) cand[1].kind = KIND_PERCENT;
            if (src_byte == CH_HASH) begin
                cand_v[1] = 1'b0;
                mode_next = MODE_COMMENT;
            end else if (is_blank(src_byte)) begin
                cand_v[1] = 1'b0;
            end else if (is_oper(src_byte)) begin
                cand_v[1] = 1'b0;
                pend_next = src_byte;
                mode_next = MODE_OPER;
            end else if (src_byte == CH_QUOTE) begin
                cand_v[1] = 1'b0;
                run_next  = '0;
                mode_next = MODE_STRING;
            end else if (is_digit(src_byte)) begin
                cand_v[1] = 1'b0;
                run_next  = LEN_W'(1);
                mode_next = MODE_NUMBER;
            end else if (is_alpha(src_byte)) begin
                cand_v[1] = 1'b0;
                wbuf_next[0] = src_byte;
                run_next  = LEN_W'(1);
                mode_next = MODE_WORD;
            end
        end

        if (src_byte == CH_NL) begin
            if (line_reg != POS_MAX) line_next = line_reg + 1'b1;
            col_next = POS_W'(1);
        end else if (col_reg != POS_MAX) begin
            col_next = col_reg + 1'b1;
        end

        // The word closed by the end of the source is classified before the state is cleared.
        for (int i = 0; i < WORD_BUF_LEN; i++) begin
            buf_new[i*8 +: 8] = wbuf_next[i];
        end
        wk_new = word_kind(buf_new, run_next);

        cand[2].line   = tline_next;
        cand[2].column = tcol_next;
        cand[2].length = run_next;
        cand[3] = '{kind: KIND_END, native: '0, length: '0,
                    line: line_next, column: col_next, final_tok: 1'b1};
        if (src_last) begin
            cand_v[3] = 1'b1;
            case (mode_next)
                MODE_WORD: begin
                    cand_v[2] = 1'b1;
                    if (run_next <= LEN_W'(WORD_BUF_LEN)) begin
                        cand[2].kind   = wk_new[KIND_W+NAT_W-1:NAT_W];
                        cand[2].native = wk_new[NAT_W-1:0];
                    end else begin
                        cand[2].kind = KIND_IDENT;
                    end
                end
                MODE_NUMBER: begin
                    cand_v[2] = 1'b1;
                    cand[2].kind = KIND_INT;
                end
                MODE_STRING: begin
                    cand_v[2] = 1'b1;
                    cand[2].kind = KIND_STRING;
                end
                MODE_OPER: begin
                    cand_v[2] = 1'b1;
                    cand[2].kind = oper_single(pend_next);
                    cand[2].length = LEN_W'(1);
                end
                default: ;
            endcase
            mode_next  = MODE_IDLE;
            pend_next  = '0;
            run_next   = '0;
            tline_next = POS_W'(1);
            tcol_next  = POS_W'(1);
            line_next  = POS_W'(1);
            col_next   = POS_W'(1);
        end
    end

    always_comb begin
        cnt = '0;
        for (int i = 0; i < MAX_RESULTS; i++) tok_out[i] = cand[3];
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && (cnt < 2'd3)) begin
                tok_out[cnt] = cand[i];
                cnt = cnt + 1'b1;
            end
        end
        tok_count = fire ? cnt : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= '0;
            run_reg   <= '0;
            tline_reg <= POS_W'(1);
            tcol_reg  <= POS_W'(1);
            line_reg  <= POS_W'(1);
            col_reg   <= POS_W'(1);
        end else if (fire) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            run_reg   <= run_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) wbuf_reg <= wbuf_next;
    end

endmodule

### hdl/sbt_out_queue.sv
// Result queue that takes up to three tokens per cycle and releases one per transfer.
module sbt_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sbt_pkg::token_t      push_tok [sbt_pkg::MAX_RESULTS],
    input  logic [1:0]           push_count,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sbt_pkg::token_t      out_tok
);
    import sbt_pkg::*;

    token_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]     count_reg, count_next;
    logic                     pop;

    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg + (QUEUE_PTR_W+1)'(MAX_RESULTS)) <=
                       (QUEUE_PTR_W+1)'(QUEUE_DEPTH);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + (QUEUE_PTR_W+1)'(push_count) - (QUEUE_PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < push_count) mem_reg[wr_ptr_reg + QUEUE_PTR_W'(i)] <= push_tok[i];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |-> room)
        else $error("tokens pushed without room");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule
